### hdl/ndl_pkg.sv
`timescale 1ns / 1ps

package ndl_pkg;

    localparam int MAX_ENTRIES_DEF  = 64;
    localparam int LINEAR_LIMIT_DEF = 16;

    // bytes of the data block header ahead of the first entry
    localparam logic [23:0] DATA_HDR_BYTES = 24'd4;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_SIZE  = 2'd2;

    localparam logic [1:0] CMD_NAME_WR = 2'd0;
    localparam logic [1:0] CMD_NODE_WR = 2'd1;
    localparam logic [1:0] CMD_SEARCH  = 2'd2;

    typedef struct packed {
        logic [5:0] entry;
        logic [6:0] right;
        logic [6:0] left;
        logic [6:0] bit_idx;
    } t_node;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_WALK,
        S_NAME,
        S_LIN,
        S_RESP
    } t_state;

endpackage

### hdl/ndl_ifs.sv
`timescale 1ns / 1ps

interface ndl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [6:0]  slot;
    logic [31:0] name_word0;
    logic [31:0] name_word1;
    logic [31:0] name_word2;
    logic [31:0] name_word3;
    logic [6:0]  node_bit_index;
    logic [6:0]  left_child;
    logic [6:0]  right_child;
    logic [5:0]  node_entry;

    modport source (
        output valid, command, slot, name_word0, name_word1, name_word2, name_word3,
               node_bit_index, left_child, right_child, node_entry,
        input  ready
    );
    modport sink (
        input  valid, command, slot, name_word0, name_word1, name_word2, name_word3,
               node_bit_index, left_child, right_child, node_entry,
        output ready
    );
endinterface

interface ndl_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [5:0]  entry_index;
    logic [23:0] data_offset;

    modport source (
        output valid, found, entry_index, data_offset,
        input  ready
    );
    modport sink (
        input  valid, found, entry_index, data_offset,
        output ready
    );
endinterface

### hdl/name_dictionary_lookup.sv
`timescale 1ns / 1ps

// channel   dir   handshake      payload
// i_req     in    valid/ready    command, slot, name_word0..3, node fields
// o_rsp     out   valid/ready    found, entry_index, data_offset
// i_cfg_*   in    write enable   register index, write data (no read-back)
//
// writes: the result is loaded from the response state once the output register is free
// linear search: compares up to entry_count names, one name memory read per cycle
// trie search: one node memory read for the header and for each visited node, then at most one name read
// reset clears the trie valid bits at once; name slots are undefined until written
// one request at a time; a held result stalls only the final output load

module name_dictionary_lookup #(
    parameter int MAX_ENTRIES  = ndl_pkg::MAX_ENTRIES_DEF,
    parameter int LINEAR_LIMIT = ndl_pkg::LINEAR_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ndl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ndl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    ndl_req_if.sink                         i_req,
    ndl_rsp_if.source                       o_rsp
);

    localparam int NAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NDW = $clog2(MAX_ENTRIES + 1);
    localparam int NDEPTH = MAX_ENTRIES + 1;

    // configuration
    logic [6:0]  r_entry_count;
    logic [15:0] r_data_start;
    logic [15:0] r_data_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_data_start  <= '0;
            r_data_size   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ndl_pkg::CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data[6:0];
                ndl_pkg::CFG_DATA_START:  r_data_start  <= i_cfg_data;
                ndl_pkg::CFG_ENTRY_SIZE:  r_data_size   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ndl_pkg::t_state r_state, n_state;
    logic [7:0]      r_idx, n_idx;
    ndl_pkg::t_node  r_parent, n_parent;
    logic            r_res_found, n_res_found;
    logic [5:0]      r_res_idx, n_res_idx;
    logic [127:0]    r_key;

    logic r_out_valid;
    logic r_out_found;
    logic [5:0]  r_out_idx;
    logic [23:0] r_out_off;

    logic req_fire;
    assign i_req.ready = (r_state == ndl_pkg::S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;

    // trie node memory with valid bits
    ndl_pkg::t_node node_mem [NDEPTH];
    logic [NDEPTH-1:0] r_node_vld;
    ndl_pkg::t_node r_node_rdata;
    logic           r_node_hit;
    ndl_pkg::t_node node_val;
    logic           node_rd_en;
    logic [7:0]     node_rd_addr;
    logic           node_we;
    logic [7:0]     req_slot;
    ndl_pkg::t_node node_wdata;

    assign req_slot = {1'b0, i_req.slot};
    assign node_we  = req_fire && (i_req.command == ndl_pkg::CMD_NODE_WR)
                      && (req_slot <= 8'(MAX_ENTRIES));
    assign node_wdata = '{entry: i_req.node_entry, right: i_req.right_child,
                          left: i_req.left_child, bit_idx: i_req.node_bit_index};

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[req_slot[NDW-1:0]] <= node_wdata;
        end
        if (node_rd_en) begin
            r_node_rdata <= node_mem[node_rd_addr[NDW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_vld <= '0;
            r_node_hit <= 1'b0;
        end else begin
            if (node_we) begin
                r_node_vld[req_slot[NDW-1:0]] <= 1'b1;
            end
            if (node_rd_en) begin
                // links past the last slot read as an all-zero node
                r_node_hit <= (node_rd_addr <= 8'(MAX_ENTRIES))
                              && r_node_vld[node_rd_addr[NDW-1:0]];
            end
        end
    end

    assign node_val = r_node_hit ? r_node_rdata : '0;

    // name memory
    logic [127:0] name_mem [MAX_ENTRIES];
    logic [127:0] r_name_rdata;
    logic         name_rd_en;
    logic [7:0]   name_rd_addr;
    logic         name_we;

    assign name_we = req_fire && (i_req.command == ndl_pkg::CMD_NAME_WR)
                     && (req_slot < 8'(MAX_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (name_we) begin
            name_mem[req_slot[NAW-1:0]] <= {i_req.name_word3, i_req.name_word2,
                                            i_req.name_word1, i_req.name_word0};
        end
        if (name_rd_en) begin
            r_name_rdata <= name_mem[name_rd_addr[NAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_key <= {i_req.name_word3, i_req.name_word2, i_req.name_word1, i_req.name_word0};
        end
    end

    // sequencer
    logic       name_match;
    logic [7:0] lin_next;
    logic [7:0] cur_entry;
    logic       cur_entry_ok;
    logic       tested_bit;
    logic       out_free;

    assign name_match   = (r_name_rdata == r_key);
    assign lin_next     = r_idx + 8'd1;
    assign cur_entry    = {2'b00, node_val.entry};
    assign cur_entry_ok = (cur_entry < {1'b0, r_entry_count}) && (cur_entry < 8'(MAX_ENTRIES));
    assign tested_bit   = r_key[node_val.bit_idx];
    assign out_free     = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_parent     = r_parent;
        n_res_found  = r_res_found;
        n_res_idx    = r_res_idx;
        node_rd_en   = 1'b0;
        node_rd_addr = '0;
        name_rd_en   = 1'b0;
        name_rd_addr = r_idx;

        unique case (r_state)
            ndl_pkg::S_IDLE: begin
                n_res_found = 1'b0;
                n_res_idx   = '0;
                if (req_fire) begin
                    if (i_req.command == ndl_pkg::CMD_SEARCH) begin
                        if (r_entry_count < 7'(LINEAR_LIMIT)) begin
                            n_idx        = '0;
                            name_rd_en   = 1'b1;
                            name_rd_addr = '0;
                            n_state = (r_entry_count == '0) ? ndl_pkg::S_RESP
                                                            : ndl_pkg::S_LIN;
                        end else begin
                            node_rd_en   = 1'b1;
                            node_rd_addr = '0;
                            n_state      = ndl_pkg::S_HDR;
                        end
                    end else begin
                        n_state = ndl_pkg::S_RESP;
                    end
                end
            end
            ndl_pkg::S_LIN: begin
                if (name_match) begin
                    n_res_found = 1'b1;
                    n_res_idx   = r_idx[5:0];
                    n_state     = ndl_pkg::S_RESP;
                end else if ((lin_next < {1'b0, r_entry_count})
                             && (lin_next < 8'(MAX_ENTRIES))) begin
                    n_idx        = lin_next;
                    name_rd_en   = 1'b1;
                    name_rd_addr = lin_next;
                end else begin
                    n_state = ndl_pkg::S_RESP;
                end
            end
            ndl_pkg::S_HDR: begin
                n_parent = node_val;
                if (node_val.left == '0) begin
                    n_state = ndl_pkg::S_RESP;
                end else begin
                    node_rd_en   = 1'b1;
                    node_rd_addr = {1'b0, node_val.left};
                    n_state      = ndl_pkg::S_WALK;
                end
            end
            ndl_pkg::S_WALK: begin
                // walk ends once the bit index stops decreasing
                if (r_parent.bit_idx > node_val.bit_idx) begin
                    n_parent     = node_val;
                    node_rd_en   = 1'b1;
                    node_rd_addr = tested_bit ? {1'b0, node_val.right}
                                              : {1'b0, node_val.left};
                end else if (cur_entry_ok) begin
                    n_idx        = cur_entry;
                    name_rd_en   = 1'b1;
                    name_rd_addr = cur_entry;
                    n_state      = ndl_pkg::S_NAME;
                end else begin
                    n_state = ndl_pkg::S_RESP;
                end
            end
            ndl_pkg::S_NAME: begin
                if (name_match) begin
                    n_res_found = 1'b1;
                    n_res_idx   = r_idx[5:0];
                end
                n_state = ndl_pkg::S_RESP;
            end
            ndl_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = ndl_pkg::S_IDLE;
                end
            end
            default: n_state = ndl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ndl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_parent    <= n_parent;
        r_res_found <= n_res_found;
        r_res_idx   <= n_res_idx;
    end

    // result register
    logic [21:0] w_prod;
    logic [23:0] w_offset;
    logic        out_load;

    assign w_prod   = 22'(r_data_size) * 22'(r_res_idx);
    assign w_offset = 24'(r_data_start) + 24'(w_prod) + ndl_pkg::DATA_HDR_BYTES;
    assign out_load = (r_state == ndl_pkg::S_RESP) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_found <= r_res_found;
            r_out_idx   <= r_res_found ? r_res_idx : '0;
            r_out_off   <= r_res_found ? w_offset : '0;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.entry_index = r_out_idx;
    assign o_rsp.data_offset = r_out_off;

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state != ndl_pkg::S_IDLE))
        else $error("sequencer idle right after a request");

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.found) |-> ({1'b0, o_rsp.entry_index} < r_entry_count))
        else $error("reported entry beyond entry count");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |-> (o_rsp.entry_index == '0 && o_rsp.data_offset == '0))
        else $error("miss result carries nonzero fields");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ndl_pkg::S_LIN) |-> (r_idx < {1'b0, r_entry_count}))
        else $error("linear scan index past entry count");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int DICT_SLOTS   = ndl_pkg::MAX_ENTRIES_DEF;
    localparam int LIN_LIMIT    = ndl_pkg::LINEAR_LIMIT_DEF;
    localparam int RANDOM_ITEMS = 1300;
    localparam int SETTLE       = 4;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int MAX_REPORTS  = 40;

    // command code the block accepts and answers with a miss
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]   command;
        logic [6:0]   slot;
        logic [127:0] name;
        logic [6:0]   bit_idx;
        logic [6:0]   left;
        logic [6:0]   right;
        logic [5:0]   entry;
    } t_dict_req;

    typedef struct packed {
        logic        found;
        logic [5:0]  idx;
        logic [23:0] off;
    } t_lookup_result;

    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_HOLD} t_rx_style;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [ndl_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ndl_pkg::CFG_DATA_W-1:0] i_cfg_data;

    ndl_req_if req_ch ();
    ndl_rsp_if rsp_ch ();

    name_dictionary_lookup DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source)
    );

    // shadow copy of the dictionary and its registers
    logic [127:0]   name_store [0:DICT_SLOTS-1];
    ndl_pkg::t_node node_store [0:DICT_SLOTS];
    ndl_pkg::t_node trie_plan  [0:DICT_SLOTS];
    logic [6:0]     cfg_entry_count;
    logic [15:0]    cfg_data_start;
    logic [15:0]    cfg_entry_size;

    t_lookup_result expected_lookups [$];
    int err_cnt     = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int cycle_cnt   = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [127:0] rand_name();
        return {$urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic ndl_pkg::t_node make_node(input logic [6:0] bit_idx,
                                                 input logic [6:0] left,
                                                 input logic [6:0] right,
                                                 input logic [5:0] entry);
        ndl_pkg::t_node nd;
        nd.bit_idx = bit_idx;
        nd.left    = left;
        nd.right   = right;
        nd.entry   = entry;
        return nd;
    endfunction

    function automatic t_dict_req random_request();
        t_dict_req r;
        r.command = 2'($urandom_range(0, 3));
        r.slot    = 7'($urandom_range(0, 127));
        r.name    = rand_name();
        r.bit_idx = 7'($urandom_range(0, 127));
        r.left    = 7'($urandom_range(0, 127));
        r.right   = 7'($urandom_range(0, 127));
        r.entry   = 6'($urandom_range(0, 63));
        return r;
    endfunction

    function automatic t_dict_req search_req(input logic [127:0] key);
        t_dict_req r;
        r = random_request();
        r.command = ndl_pkg::CMD_SEARCH;
        r.name    = key;
        return r;
    endfunction

    function automatic t_dict_req name_write(input int slot, input logic [127:0] key);
        t_dict_req r;
        r = random_request();
        r.command = ndl_pkg::CMD_NAME_WR;
        r.slot    = 7'(slot);
        r.name    = key;
        return r;
    endfunction

    function automatic t_dict_req node_write(input int slot, input ndl_pkg::t_node nd);
        t_dict_req r;
        r = random_request();
        r.command = ndl_pkg::CMD_NODE_WR;
        r.slot    = 7'(slot);
        r.bit_idx = nd.bit_idx;
        r.left    = nd.left;
        r.right   = nd.right;
        r.entry   = nd.entry;
        return r;
    endfunction

    function automatic ndl_pkg::t_node fetch_node(input logic [6:0] s);
        if (s > DICT_SLOTS)
            return '0;
        return node_store[s];
    endfunction

    // applies one request to the shadow state and returns the lookup it should produce
    function automatic t_lookup_result predict_lookup(input t_dict_req r);
        t_lookup_result res;
        ndl_pkg::t_node par, cur;
        logic [6:0] nxt;
        logic [31:0] off;
        int hit, i;
        res = '0;
        hit = -1;
        case (r.command)
            ndl_pkg::CMD_NAME_WR: begin
                if (r.slot < DICT_SLOTS)
                    name_store[r.slot] = r.name;
            end
            ndl_pkg::CMD_NODE_WR: begin
                if (r.slot <= DICT_SLOTS)
                    node_store[r.slot] = make_node(r.bit_idx, r.left, r.right, r.entry);
            end
            ndl_pkg::CMD_SEARCH: begin
                if (cfg_entry_count < LIN_LIMIT) begin
                    for (i = 0; i < cfg_entry_count && i < DICT_SLOTS && hit < 0; i++)
                        if (name_store[i] == r.name)
                            hit = i;
                end else begin
                    par = fetch_node(7'd0);
                    if (par.left != 7'd0) begin
                        cur = fetch_node(par.left);
                        // bit indices must keep falling, otherwise the walk is over
                        while (par.bit_idx > cur.bit_idx) begin
                            nxt = r.name[cur.bit_idx] ? cur.right : cur.left;
                            par = cur;
                            cur = fetch_node(nxt);
                        end
                        if (cur.entry < cfg_entry_count && name_store[cur.entry] == r.name)
                            hit = cur.entry;
                    end
                end
                if (hit >= 0) begin
                    off = 32'(cfg_data_start) + 32'(ndl_pkg::DATA_HDR_BYTES)
                          + 32'(cfg_entry_size) * 32'(hit);
                    res.found = 1'b1;
                    res.idx   = 6'(hit);
                    res.off   = off[23:0];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_request(input t_dict_req r);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        burst_left--;
        req_ch.valid          = 1'b1;
        req_ch.command        = r.command;
        req_ch.slot           = r.slot;
        req_ch.name_word0     = r.name[31:0];
        req_ch.name_word1     = r.name[63:32];
        req_ch.name_word2     = r.name[95:64];
        req_ch.name_word3     = r.name[127:96];
        req_ch.node_bit_index = r.bit_idx;
        req_ch.left_child     = r.left;
        req_ch.right_child    = r.right;
        req_ch.node_entry     = r.entry;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1)
            @(posedge i_clk);
        expected_lookups.push_back(predict_lookup(r));
        items_sent++;
        @(negedge i_clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_lookups.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [ndl_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [15:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            ndl_pkg::CFG_ENTRY_COUNT: cfg_entry_count = val[6:0];
            ndl_pkg::CFG_DATA_START:  cfg_data_start  = val;
            ndl_pkg::CFG_ENTRY_SIZE:  cfg_entry_size  = val;
            default: ;
        endcase
    endtask

    // names for slots 0..m-1 that differ somewhere in bits 126..0, sharing all bits above k
    task automatic load_names(input int m, input int k);
        logic [127:0] base, mask, cand;
        logic [127:0] fresh [0:DICT_SLOTS-1];
        int i, j;
        bit clash;
        base = rand_name();
        mask = (k >= 128) ? '1 : ((128'd1 << k) - 128'd1);
        for (i = 0; i < m; i++) begin
            clash = 1'b1;
            while (clash) begin
                cand  = base ^ (rand_name() & mask);
                clash = 1'b0;
                for (j = 0; j < i; j++)
                    if (fresh[j][126:0] == cand[126:0])
                        clash = 1'b1;
            end
            fresh[i] = cand;
            send_request(name_write(i, cand));
        end
    endtask

    // patricia insert of entries 0..m-1 into node slots 1..m, then load the nodes
    task automatic build_trie(input int m);
        logic [127:0] key, diff;
        int i, e, s, ps, cs, d, rot;
        trie_plan[0] = make_node(7'd127, 7'd0, 7'($urandom_range(0, 64)),
                                 6'($urandom_range(0, 63)));
        rot = $urandom_range(0, m - 1);
        for (i = 0; i < m; i++) begin
            e   = (i + rot) % m;
            s   = e + 1;
            key = name_store[e];
            if (trie_plan[0].left == 7'd0) begin
                trie_plan[s]      = make_node(7'd126, 7'(s), 7'(s), 6'(e));
                trie_plan[0].left = 7'(s);
            end else begin
                ps = 0;
                cs = trie_plan[0].left;
                while (trie_plan[ps].bit_idx > trie_plan[cs].bit_idx) begin
                    ps = cs;
                    cs = key[trie_plan[cs].bit_idx] ? trie_plan[cs].right : trie_plan[cs].left;
                end
                diff = key ^ name_store[trie_plan[cs].entry];
                d = 126;
                while (d > 0 && !diff[d])
                    d--;
                ps = 0;
                cs = trie_plan[0].left;
                while (trie_plan[ps].bit_idx > trie_plan[cs].bit_idx &&
                       trie_plan[cs].bit_idx > d) begin
                    ps = cs;
                    cs = key[trie_plan[cs].bit_idx] ? trie_plan[cs].right : trie_plan[cs].left;
                end
                if (key[d])
                    trie_plan[s] = make_node(7'(d), 7'(cs), 7'(s), 6'(e));
                else
                    trie_plan[s] = make_node(7'(d), 7'(s), 7'(cs), 6'(e));
                if (ps == 0)
                    trie_plan[0].left = 7'(s);
                else if (key[trie_plan[ps].bit_idx])
                    trie_plan[ps].right = 7'(s);
                else
                    trie_plan[ps].left = 7'(s);
            end
        end
        for (i = 1; i <= m; i++)
            send_request(node_write(i, trie_plan[i]));
        send_request(node_write(0, trie_plan[0]));
    endtask

    // nothing here may read a name slot, none has been written yet
    task automatic test_reset_state();
        t_dict_req r;
        r = search_req('1);
        r.command = CMD_UNUSED;
        r.slot    = 7'h7f;
        r.bit_idx = 7'h7f;
        r.left    = 7'h7f;
        r.right   = 7'h7f;
        r.entry   = 6'h3f;
        send_request(r);
        send_request(search_req(rand_name()));
        send_request(node_write(127, make_node(7'd127, 7'd1, 7'd1, 6'd0)));
        send_request(node_write(DICT_SLOTS, make_node(7'd127, 7'd127, 7'd64, 6'd63)));
        send_request(name_write(64, '1));
        send_request(name_write(127, '1));
        wait_idle();
        write_register(ndl_pkg::CFG_ENTRY_COUNT, 16'd16);
        send_request(search_req('0));
    endtask

    task automatic test_linear_scan();
        logic [127:0] dup;
        wait_idle();
        write_register(ndl_pkg::CFG_ENTRY_COUNT, 16'd15);
        write_register(ndl_pkg::CFG_DATA_START, 16'hffff);
        write_register(ndl_pkg::CFG_ENTRY_SIZE, 16'hffff);
        send_request(search_req(name_store[0]));
        send_request(search_req(name_store[14]));
        send_request(search_req(name_store[15]));
        send_request(search_req(~name_store[3]));
        // same name twice: the lower entry wins
        dup = name_store[2];
        send_request(name_write(9, dup));
        send_request(search_req(dup));
        send_request(name_write(5, '0));
        send_request(search_req('0));
        send_request(name_write(6, '1));
        send_request(search_req('1));
        wait_idle();
        write_register(ndl_pkg::CFG_ENTRY_COUNT, 16'd0);
        send_request(search_req(name_store[0]));
        wait_idle();
        write_register(ndl_pkg::CFG_ENTRY_COUNT, 16'd1);
        send_request(search_req(name_store[0]));
    endtask

    task automatic test_trie_search();
        wait_idle();
        write_register(ndl_pkg::CFG_ENTRY_COUNT, 16'd64);
        write_register(ndl_pkg::CFG_DATA_START, 16'h0000);
        write_register(ndl_pkg::CFG_ENTRY_SIZE, 16'h0000);
        load_names(DICT_SLOTS, 128);
        build_trie(DICT_SLOTS);
        send_request(search_req(name_store[0]));
        send_request(search_req(name_store[63]));
        send_request(search_req(name_store[5] ^ 128'd1));
        // bit 127 is never tested, so only the final compare can reject this
        send_request(search_req(name_store[6] ^ (128'd1 << 127)));
        wait_idle();
        write_register(ndl_pkg::CFG_ENTRY_COUNT, 16'd20);
        send_request(search_req(name_store[19]));
        send_request(search_req(name_store[40]));
    endtask

    task automatic test_walk_corners();
        int k;
        // root link past the node store reads a zero node, which leads back to the header
        send_request(node_write(0, make_node(7'd127, 7'd100, 7'd0, 6'd7)));
        send_request(search_req(name_store[7]));
        send_request(search_req(name_store[8]));
        // empty trie
        send_request(node_write(0, make_node(7'd127, 7'd0, 7'd64, 6'd63)));
        send_request(search_req(name_store[7]));
        // one long chain through every node slot, the last one points back up to slot 1
        for (k = 1; k <= DICT_SLOTS; k++)
            send_request(node_write(k, make_node(7'(127 - k),
                7'((k < DICT_SLOTS) ? k + 1 : 1), 7'((k < DICT_SLOTS) ? k + 1 : 1),
                6'((k == 1) ? 0 : $urandom_range(0, 63)))));
        send_request(node_write(0, make_node(7'd127, 7'd1, 7'd0, 6'd0)));
        send_request(search_req(name_store[0]));
        send_request(search_req(name_store[1]));
        send_request(node_write(100, make_node(7'd0, 7'd0, 7'd0, 6'd1)));
        send_request(search_req(name_store[0]));
    endtask

    task automatic test_random_rounds();
        t_dict_req r;
        int goal, n, m, searches, i, sel, pool;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            wait_idle();
            case ($urandom_range(0, 7))
                0: n = 0;
                1: n = $urandom_range(1, LIN_LIMIT - 1);
                2: n = LIN_LIMIT - 1;
                3: n = LIN_LIMIT;
                4: n = DICT_SLOTS;
                default: n = $urandom_range(LIN_LIMIT, DICT_SLOTS);
            endcase
            write_register(ndl_pkg::CFG_ENTRY_COUNT, 16'(n));
            write_register(ndl_pkg::CFG_DATA_START, pick16());
            write_register(ndl_pkg::CFG_ENTRY_SIZE, pick16());
            if (n >= LIN_LIMIT)
                m = ($urandom_range(0, 3) == 0) ? $urandom_range(1, DICT_SLOTS) : n;
            else
                m = ($urandom_range(0, 1) == 0) ? n : $urandom_range(n, DICT_SLOTS);
            if (m > 0)
                load_names(m, $urandom_range(8, 128));
            if (n >= LIN_LIMIT)
                build_trie(m);
            pool = (m > 0) ? m : DICT_SLOTS;
            searches = $urandom_range(15, 60);
            for (i = 0; i < searches; i++) begin
                if ($urandom_range(0, 49) == 0)
                    wait_idle();
                sel = $urandom_range(0, 99);
                if (sel < 60) begin
                    send_request(search_req(name_store[$urandom_range(0, pool - 1)]));
                end else if (sel < 72) begin
                    send_request(search_req(name_store[$urandom_range(0, DICT_SLOTS - 1)] ^
                                            (128'd1 << $urandom_range(0, 127))));
                end else if (sel < 80) begin
                    send_request(search_req(rand_name()));
                end else begin
                    // any command on any slot; some carry a copy of a stored name
                    r = random_request();
                    if (sel < 86)
                        r.name = name_store[$urandom_range(0, DICT_SLOTS - 1)];
                    send_request(r);
                end
            end
        end
    endtask

    initial begin : rsp_stall_pattern
        t_rx_style style;
        int span;
        rsp_ch.ready = 1'b0;
        forever begin
            style = t_rx_style'($urandom_range(0, 3));
            span  = $urandom_range(4, 50);
            repeat (span) begin
                @(negedge i_clk);
                case (style)
                    RX_OPEN:   rsp_ch.ready = 1'b1;
                    RX_COIN:   rsp_ch.ready = 1'($urandom_range(0, 1));
                    RX_MOSTLY: rsp_ch.ready = ($urandom_range(0, 7) != 0);
                    default:   rsp_ch.ready = 1'b0;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_lookups
        t_lookup_result want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (expected_lookups.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected result found=%0b entry=%0d offset=%0d", $time,
                             rsp_ch.found, rsp_ch.entry_index, rsp_ch.data_offset);
            end else begin
                want = expected_lookups.pop_front();
                if (rsp_ch.found !== want.found) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: found expected %0b actual %0b", $time,
                                 want.found, rsp_ch.found);
                end
                if (rsp_ch.entry_index !== want.idx) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: entry_index expected %0d actual %0d", $time,
                                 want.idx, rsp_ch.entry_index);
                end
                if (rsp_ch.data_offset !== want.off) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: data_offset expected %0d actual %0d", $time,
                                 want.off, rsp_ch.data_offset);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("name_dictionary_lookup regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = ndl_pkg::CFG_ENTRY_COUNT;
        i_cfg_data            = '0;
        req_ch.valid          = 1'b0;
        req_ch.command        = ndl_pkg::CMD_SEARCH;
        req_ch.slot           = '0;
        req_ch.name_word0     = '0;
        req_ch.name_word1     = '0;
        req_ch.name_word2     = '0;
        req_ch.name_word3     = '0;
        req_ch.node_bit_index = '0;
        req_ch.left_child     = '0;
        req_ch.right_child    = '0;
        req_ch.node_entry     = '0;
        cfg_entry_count       = '0;
        cfg_data_start        = '0;
        cfg_entry_size        = '0;
        for (int s = 0; s <= DICT_SLOTS; s++)
            node_store[s] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        load_names(DICT_SLOTS, 128);
        test_linear_scan();
        test_trie_search();
        test_walk_corners();
        test_random_rounds();

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_cnt == 0)
            $display("name_dictionary_lookup regression: pass");
        else
            $display("name_dictionary_lookup regression: fail");
        $finish;
    end

endmodule

### filelist.f
hdl/ndl_pkg.sv
hdl/ndl_ifs.sv
hdl/name_dictionary_lookup.sv
bench/tb_top.sv
